// ----- src/cbc_pkg.sv -----
package cbc_pkg;

   localparam int COORD_W = 10;
   localparam int MAX_LINE_WIDTH = 1 << COORD_W;
   localparam int DIM_W = COORD_W + 1;
   localparam int PIX_W = 8;
   localparam int WEIGHT_W = 16;
   localparam int ROW_W = 3 * WEIGHT_W;
   localparam int SUM_W = 28;
   localparam int SHIFT_W = 5;
   localparam int BIAS_W = 16;

   localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_LINE_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(1024);
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = ROW_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_TOP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_MIDDLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BOTTOM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS = 3'd6;

   typedef logic [ROW_W-1:0] weight_row_type;

   typedef struct packed {
      logic [2:0][2:0][PIX_W-1:0] win;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic signed [SUM_W-1:0]    sum;
   } cbc_item_type;

endpackage

// ----- src/cbc_mac_cell.sv -----
module cbc_mac_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cbc_pkg::cbc_item_type  in_item,
   input  logic [1:0]             row_sel,
   input  cbc_pkg::weight_row_type weights,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cbc_pkg::cbc_item_type  out_item
);
   import cbc_pkg::*;

   localparam int PROD_W = PIX_W + 1 + WEIGHT_W;

   logic                       valid_ff;
   cbc_item_type               item_ff;
   cbc_item_type               item_in;
   logic signed [PROD_W-1:0]   prod [3];
   logic signed [PIX_W:0]      px [3];
   logic signed [WEIGHT_W-1:0] wt [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         px[j] = $signed({1'b0, in_item.win[row_sel][j]});
         wt[j] = $signed(weights[WEIGHT_W*j +: WEIGHT_W]);
         prod[j] = px[j] * wt[j];
      end
      item_in = in_item;
      item_in.sum = $signed(in_item.sum)
                  + $signed({{(SUM_W-PROD_W){prod[0][PROD_W-1]}}, prod[0]})
                  + $signed({{(SUM_W-PROD_W){prod[1][PROD_W-1]}}, prod[1]})
                  + $signed({{(SUM_W-PROD_W){prod[2][PROD_W-1]}}, prod[2]});
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   a_cell_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(item_ff))
      else $error("cell lost or changed a stalled request");

endmodule

// ----- src/cbc_line_buf.sv -----
module cbc_line_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [cbc_pkg::PIX_W-1:0]    in_pixel,
   input  logic                         in_frame_start,
   input  logic [cbc_pkg::DIM_W-1:0]    width,
   input  logic [cbc_pkg::DIM_W-1:0]    height,
   output logic                         out_valid,
   input  logic                         out_ready,
   output cbc_pkg::cbc_item_type        out_item
);
   import cbc_pkg::*;

   logic [COORD_W-1:0] col_ff, row_ff, col_in, row_in;
   logic [COORD_W-1:0] c0, r0, c1, r2;
   logic [DIM_W-1:0]   r1, cn, rn;
   logic               accept;
   logic               emit;

   logic [2*PIX_W-1:0] mem [MAX_LINE_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;

   logic               s1_valid_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic [COORD_W-1:0] s1_addr_ff;
   logic               s1_emit_ff;
   logic [COORD_W-1:0] s1_col_ff, s1_row_ff;
   logic               s1_fwd_ff;
   logic [2*PIX_W-1:0] s1_fwd_data_ff;
   logic [2*PIX_W-1:0] s1_entry;
   logic               s1_adv;

   logic                       s2_valid_ff;
   logic                       s2_ready;
   logic [2:0][2:0][PIX_W-1:0] win_ff;
   logic [COORD_W-1:0]         s2_col_ff, s2_row_ff;

   always_comb begin
      c0 = in_frame_start ? '0 : col_ff;
      r0 = in_frame_start ? '0 : row_ff;
      if ({1'b0, c0} >= width) begin
         c1 = '0;
         r1 = {1'b0, r0} + DIM_W'(1);
      end else begin
         c1 = c0;
         r1 = {1'b0, r0};
      end
      r2 = (r1 >= height) ? '0 : r1[COORD_W-1:0];
      cn = {1'b0, c1} + DIM_W'(1);
      rn = {1'b0, r2} + DIM_W'(1);
      if (cn >= width) begin
         col_in = '0;
         row_in = (rn >= height) ? '0 : rn[COORD_W-1:0];
      end else begin
         col_in = cn[COORD_W-1:0];
         row_in = r2;
      end
      emit = (c1 >= COORD_W'(2)) && (r2 >= COORD_W'(2));
   end

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_adv = s1_valid_ff && s2_ready;
   assign in_ready = !s1_valid_ff || s2_ready;
   assign accept = in_valid && in_ready;
   assign s1_entry = s1_fwd_ff ? s1_fwd_data_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[c1];
      end
      if (s1_adv) begin
         mem[s1_addr_ff] <= {s1_entry[PIX_W-1:0], s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= in_pixel;
         s1_addr_ff <= c1;
         s1_emit_ff <= emit;
         s1_col_ff <= c1 - COORD_W'(1);
         s1_row_ff <= r2 - COORD_W'(1);
         s1_fwd_ff <= s1_valid_ff && (s1_addr_ff == c1);
         s1_fwd_data_ff <= {s1_entry[PIX_W-1:0], s1_pix_ff};
      end
      if (s1_adv) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= s1_entry[2*PIX_W-1:PIX_W];
         win_ff[1][2] <= s1_entry[PIX_W-1:0];
         win_ff[2][2] <= s1_pix_ff;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
      end
   end

   always_comb begin
      out_item.win = win_ff;
      out_item.col = s2_col_ff;
      out_item.row = s2_row_ff;
      out_item.sum = '0;
   end
   assign out_valid = s2_valid_ff;

   a_frame_start_col: assert property (@(posedge clock) disable iff (reset)
      accept && in_frame_start |=> col_ff == COORD_W'(1))
      else $error("column counter did not restart on frame start");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("stalled line store write moved");

   a_emit_interior: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_col_ff != '0 && s2_row_ff != '0)
      else $error("border position produced a result");

endmodule

// ----- src/conv3x3_shift_bias_clamp_unit.sv -----
// Path: line store read, window register, three MAC cells, output register.
// Throughput: one request per cycle unless rsp_tready stalls it, set by the one read and
// one write per cycle of the line store and the three-cell multiply-accumulate chain.
// Reset is synchronous: counters, valid bits and CSRs return to their reset values.
// The line store and the window are not cleared; there is no clearing pass.
module conv3x3_shift_bias_clamp_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // pixel_in
   input  logic [0:0]                        req_tuser,  // frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // pixel_out, out_column, out_row
   input  logic                              csr_we,
   input  logic [cbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cbc_pkg::*;

   logic [DIM_W-1:0]   width_ff, height_ff, width_sat, height_sat;
   weight_row_type     wtop_ff, wmid_ff, wbot_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [BIAS_W-1:0]  bias_ff;

   logic         lb_valid, c0_ready, c0_valid, c1_ready, c1_valid, c2_ready, c2_valid;
   cbc_item_type lb_item, c0_item, c1_item, c2_item;

   logic                    post_ready;
   logic                    rsp_valid_ff;
   logic [PIX_W-1:0]        pix_ff, pix_in;
   logic [COORD_W-1:0]      col_ff, row_ff;
   logic signed [SUM_W-1:0] shifted;
   logic signed [SUM_W:0]   biased;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         wtop_ff <= '0;
         wmid_ff <= ROW_W'(65536);
         wbot_ff <= '0;
         shift_ff <= '0;
         bias_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: width_ff <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_WEIGHT_TOP: wtop_ff <= csr_wdata[ROW_W-1:0];
            CSR_WEIGHT_MIDDLE: wmid_ff <= csr_wdata[ROW_W-1:0];
            CSR_WEIGHT_BOTTOM: wbot_ff <= csr_wdata[ROW_W-1:0];
            CSR_SHIFT: shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_BIAS: bias_ff <= csr_wdata[BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_sat = (width_ff < DIM_MIN) ? DIM_MIN
                : (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;
      height_sat = (height_ff < DIM_MIN) ? DIM_MIN
                 : (height_ff > HEIGHT_MAX) ? HEIGHT_MAX : height_ff;
   end

   cbc_line_buf u_line_buf (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_pixel       (req_tdata),
      .in_frame_start (req_tuser[0]),
      .width          (width_sat),
      .height         (height_sat),
      .out_valid      (lb_valid),
      .out_ready      (c0_ready),
      .out_item       (lb_item)
   );

   cbc_mac_cell u_cell_top (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lb_valid),
      .in_ready  (c0_ready),
      .in_item   (lb_item),
      .row_sel   (2'd0),
      .weights   (wtop_ff),
      .out_valid (c0_valid),
      .out_ready (c1_ready),
      .out_item  (c0_item)
   );

   cbc_mac_cell u_cell_middle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c0_valid),
      .in_ready  (c1_ready),
      .in_item   (c0_item),
      .row_sel   (2'd1),
      .weights   (wmid_ff),
      .out_valid (c1_valid),
      .out_ready (c2_ready),
      .out_item  (c1_item)
   );

   cbc_mac_cell u_cell_bottom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid),
      .in_ready  (c2_ready),
      .in_item   (c1_item),
      .row_sel   (2'd2),
      .weights   (wbot_ff),
      .out_valid (c2_valid),
      .out_ready (post_ready),
      .out_item  (c2_item)
   );

   always_comb begin
      shifted = $signed(c2_item.sum) >>> shift_ff;
      biased = $signed({shifted[SUM_W-1], shifted})
             + $signed({{(SUM_W+1-BIAS_W){bias_ff[BIAS_W-1]}}, bias_ff});
      if (biased < 0) begin
         pix_in = '0;
      end else if (biased > $signed({{(SUM_W+1-PIX_W){1'b0}}, PIX_MAX})) begin
         pix_in = PIX_MAX;
      end else begin
         pix_in = biased[PIX_W-1:0];
      end
   end

   assign post_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post_ready) begin
         rsp_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (post_ready && c2_valid) begin
         pix_ff <= pix_in;
         col_ff <= c2_item.col;
         row_ff <= c2_item.row;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'd0, row_ff, col_ff, pix_ff};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(pix_ff))
      else $error("result changed while stalled");

endmodule

// ----- tb/tb_conv3x3_shift_bias_clamp_unit.sv -----
`timescale 1ns / 100ps

module tb_conv3x3_shift_bias_clamp_unit;
   import cbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic [7:0] pix;
      logic       restart;
   } pixel_request_type;

   typedef struct {
      logic [7:0] pix;
      logic [9:0] col;
      logic [9:0] row;
   } filtered_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;  // pixel_in
   logic [0:0]            req_tuser = '0;  // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;       // pixel_out, out_column, out_row
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pixel_request_type  pixel_backlog[$];
   filtered_pixel_type filtered_due[$];

   logic [10:0]        cfg_width = 11'd640;
   logic [10:0]        cfg_height = 11'd480;
   logic [47:0]        cfg_rows [0:2] = '{48'd0, 48'd65536, 48'd0};
   logic [4:0]         cfg_shift = '0;
   logic signed [15:0] cfg_bias = '0;

   logic [15:0] line_mem [0:MAX_LINE_WIDTH-1] = '{default: '0};
   logic [7:0]  win [0:2][0:2] = '{default: '0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   bit steady = 1'b0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   conv3x3_shift_bias_clamp_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void filter_pixel(input logic [7:0] pix, input logic restart);
      int unsigned w, h, c, r;
      int i, j;
      logic [15:0] entry;
      longint acc, wt, px;
      filtered_pixel_type res;
      w = cfg_width;
      h = cfg_height;
      if (w < 3) w = 3;
      if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
      if (h < 3) h = 3;
      if (h > 1024) h = 1024;
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      entry = line_mem[c];
      line_mem[c] = {entry[7:0], pix};
      for (i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = entry[15:8];
      win[1][2] = entry[7:0];
      win[2][2] = pix;

      if (c >= 2 && r >= 2) begin
         acc = 0;
         for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
               wt = $signed(cfg_rows[i][16*j +: 16]);
               px = win[i][j];
               acc += wt * px;
            end
         end
         acc = (acc >>> cfg_shift) + cfg_bias;
         if (acc < 0) acc = 0;
         else if (acc > 255) acc = 255;
         res.pix = acc[7:0];
         res.col = 10'(c - 1);
         res.row = 10'(r - 1);
         filtered_due.push_back(res);
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : drive_req
      pixel_request_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) filter_pixel(req_tdata, req_tuser[0]);
         if (!req_tvalid || req_tready) begin
            if (pixel_backlog.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
               next_req = pixel_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_req.pix;
               req_tuser <= next_req.restart;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin : check_rsp
      filtered_pixel_type want;
      logic [31:0] want_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_due.size() == 0) begin
            flag_mismatch("unexpected result", 32'h0, rsp_tdata);
         end else begin
            want = filtered_due.pop_front();
            want_word = {4'b0, want.row, want.col, want.pix};
            if (rsp_tdata[7:0] !== want.pix || rsp_tdata[17:8] !== want.col
                || rsp_tdata[27:18] !== want.row || rsp_tdata[31:28] !== 4'b0)
               flag_mismatch("filtered pixel differs", want_word, rsp_tdata);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("No transfer for %0d cycles.", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [47:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:   cfg_width = value[10:0];
         CSR_FRAME_HEIGHT:  cfg_height = value[10:0];
         CSR_WEIGHT_TOP:    cfg_rows[0] = value;
         CSR_WEIGHT_MIDDLE: cfg_rows[1] = value;
         CSR_WEIGHT_BOTTOM: cfg_rows[2] = value;
         CSR_SHIFT:         cfg_shift = value[4:0];
         CSR_BIAS:          cfg_bias = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_filter(input logic [10:0] width, input logic [10:0] height,
                                 input logic [47:0] top, input logic [47:0] middle,
                                 input logic [47:0] bottom, input logic [4:0] shift,
                                 input logic [15:0] bias);
      logic [47:0] junk;
      junk = 48'({$urandom(), $urandom()});
      write_csr(CSR_FRAME_WIDTH, {junk[47:11], width});
      write_csr(CSR_FRAME_HEIGHT, {junk[36:0], height});
      write_csr(CSR_WEIGHT_TOP, top);
      write_csr(CSR_WEIGHT_MIDDLE, middle);
      write_csr(CSR_WEIGHT_BOTTOM, bottom);
      write_csr(CSR_SHIFT, {junk[42:0], shift});
      write_csr(CSR_BIAS, {junk[31:0], bias});
   endtask

   task automatic wait_idle(input int settle);
      do @(negedge clock);
      while (pixel_backlog.size() != 0 || req_tvalid || filtered_due.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic push_pixel(input logic [7:0] pix, input logic restart);
      pixel_request_type p;
      p.pix = pix;
      p.restart = restart;
      pixel_backlog.push_back(p);
   endtask

   task automatic queue_pixels(input int count, input bit restart, input int noise_pct);
      int k;
      logic [7:0] pix;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0: pix = 8'd0;
            1: pix = 8'd255;
            default: pix = 8'($urandom());
         endcase
         push_pixel(pix, (k == 0 && restart) || ($urandom_range(99) < noise_pct));
      end
   endtask

   function automatic logic [47:0] kernel_row(input int span);
      logic [47:0] row;
      int j;
      row = 48'({$urandom(), $urandom()});
      if (span > 0)
         for (j = 0; j < 3; j++) row[16*j +: 16] = 16'($urandom_range(2 * span) - span);
      return row;
   endfunction

   initial begin : stimulus
      int k, phase, span;
      logic [10:0] width, height;
      logic [4:0] shift;
      int bias;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Tiny frames with extreme weights; width and height below range saturate to 3.
      program_filter(11'd1, 11'd0, {16'h0001, 16'h7FFF, 16'h8000},
                     {16'h7FFF, 16'h0000, 16'hFFFF}, {16'h8000, 16'h0002, 16'h7FFF},
                     5'd0, 16'd0);
      write_csr(CSR_UNUSED, 48'hFFFF_FFFF_FFFF);
      for (k = 0; k < 9; k++) push_pixel(8'd255, k == 0);
      // Second frame follows by wrap-around, then a fresh frame starts mid-line.
      for (k = 0; k < 11; k++) push_pixel(k[0] ? 8'd255 : 8'd0, 1'b0);
      for (k = 0; k < 5; k++) push_pixel(8'($urandom()), k == 0);

      for (phase = 0; phase < 10; phase++) begin
         wait_idle(SETTLE_CYCLES);
         if (phase != 5) width = 11'($urandom_range(3, 14));
         height = 11'($urandom_range(3, 7));
         span = (phase < 2 || $urandom_range(3) == 0) ? 0 : 12;
         shift = (span == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(2, 5));
         bias = $urandom_range(400) - 150;
         if (phase == 0) begin
            shift = 5'd31;
            bias = 32767;
         end else if (phase == 1) begin
            shift = 5'd0;
            bias = -32768;
         end
         program_filter(width, height, kernel_row(span), kernel_row(span),
                        kernel_row(span), shift, 16'(bias));
         steady = (phase == 7);
         if (phase == 3) begin
            queue_pixels(40, 1'b1, 2);
            wait_idle(0);
            queue_pixels(40, 1'b0, 2);
         end else begin
            queue_pixels((phase == 7) ? 160 : 50, phase != 5, 2);
         end
      end

      // A width above range saturates to the longest line; only its first columns are sent.
      wait_idle(SETTLE_CYCLES);
      program_filter(11'd1500, 11'd2, kernel_row(12), kernel_row(12), kernel_row(12),
                     5'd4, 16'($urandom_range(200) - 100));
      queue_pixels(70, 1'b1, 0);

      // Tallest frame on the narrowest line; only its first rows are sent.
      wait_idle(SETTLE_CYCLES);
      program_filter(11'd0, 11'd2047, kernel_row(12), kernel_row(12), kernel_row(12),
                     5'd3, 16'($urandom_range(200) - 100));
      queue_pixels(60, 1'b1, 0);

      wait_idle(SETTLE_CYCLES);
      if (mismatch_count == 0 && filtered_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
